// ===== design/extended_euclid_bezout_unit_defines.svh =====
// Assertion macros shared by the Bezout unit.
`ifndef EXTENDED_EUCLID_BEZOUT_UNIT_DEFINES_SVH
`define EXTENDED_EUCLID_BEZOUT_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define EBZ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define EBZ_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

// ===== design/ebz_pkg.sv =====
`default_nettype none

package ebz_pkg;

   localparam int WIDTH_DEFAULT = 32;

   localparam int STATE_W = 2;
   localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
   localparam logic [STATE_W-1:0] ST_DIV  = 2'd1;
   localparam logic [STATE_W-1:0] ST_UPD  = 2'd2;
   localparam logic [STATE_W-1:0] ST_FIN  = 2'd3;

endpackage

`default_nettype wire

// ===== design/ebz_if.sv =====
`default_nettype none

// Operand channel: one transfer carries the pair x, y.
interface ebz_req_if #(
   parameter int WIDTH = ebz_pkg::WIDTH_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] x_value;
   logic signed [WIDTH-1:0] y_value;

   modport source (output valid, output x_value, output y_value, input ready);
   modport sink   (input valid, input x_value, input y_value, output ready);
endinterface

// Result channel: coefficients, gcd and the zero divisor flag.
interface ebz_rsp_if #(
   parameter int WIDTH = ebz_pkg::WIDTH_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] coef_x;
   logic signed [WIDTH-1:0] coef_y;
   logic        [WIDTH-2:0] divisor_out;
   logic                    zero_divisor;

   modport source (output valid, output coef_x, output coef_y, output divisor_out,
                   output zero_divisor, input ready);
   modport sink   (input valid, input coef_x, input coef_y, input divisor_out,
                   input zero_divisor, output ready);
endinterface

`default_nettype wire

// ===== design/extended_euclid_bezout_unit.sv =====
// Channel    Direction  Transfer carries
// req_chan   in         x_value, y_value
// rsp_chan   out        coef_x, coef_y, divisor_out, zero_divisor
//
// An item runs R Euclid rounds, R being the number of rounds needed
// (up to about 46 for 32-bit operands). Each round runs a restoring divider that
// makes one quotient bit per cycle, followed by the coefficient update.
// A zero y operand skips the division. req_chan is ready only while the unit is idle.
// Reset is synchronous; a held result waits in the output register.
`default_nettype none

`include "extended_euclid_bezout_unit_defines.svh"

module extended_euclid_bezout_unit #(
   parameter int WIDTH = ebz_pkg::WIDTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ebz_req_if.sink    req_chan,
   ebz_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(WIDTH);

   logic [ebz_pkg::STATE_W-1:0] state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] acck_ff, acck_in;
   logic [WIDTH-1:0] accl_ff, accl_in;
   logic [WIDTH-1:0] kc_ff, kc_in;
   logic [WIDTH-1:0] ku_ff, ku_in;
   logic [WIDTH-1:0] lc_ff, lc_in;
   logic [WIDTH-1:0] lv_ff, lv_in;
   logic             xneg_ff, xneg_in;
   logic             yneg_ff, yneg_in;
   logic             zero_ff, zero_in;

   logic signed [WIDTH-1:0] coef_x_ff, coef_x_in;
   logic signed [WIDTH-1:0] coef_y_ff, coef_y_in;
   logic        [WIDTH-2:0] gcd_ff, gcd_in;
   logic                    zflag_ff, zflag_in;

   logic [WIDTH-1:0] x_raw, y_raw, x_mag, y_mag;
   logic [WIDTH:0]   shifted;
   logic             ge;
   logic             req_fire, load_out;

   assign x_raw = req_chan.x_value;
   assign y_raw = req_chan.y_value;
   assign x_mag = x_raw[WIDTH-1] ? (~x_raw + WIDTH'(1)) : x_raw;
   assign y_mag = y_raw[WIDTH-1] ? (~y_raw + WIDTH'(1)) : y_raw;

   assign req_chan.ready = (state_ff == ebz_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // One restoring division step: bring down the next dividend bit.
   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign ge      = (shifted >= {1'b0, b_ff});

   assign load_out = (state_ff == ebz_pkg::ST_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      b_in         = b_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      acck_in      = acck_ff;
      accl_in      = accl_ff;
      kc_in        = kc_ff;
      ku_in        = ku_ff;
      lc_in        = lc_ff;
      lv_in        = lv_ff;
      xneg_in      = xneg_ff;
      yneg_in      = yneg_ff;
      zero_in      = zero_ff;
      coef_x_in    = coef_x_ff;
      coef_y_in    = coef_y_ff;
      gcd_in       = gcd_ff;
      zflag_in     = zflag_ff;

      case (state_ff)
         ebz_pkg::ST_IDLE: begin
            if (req_fire) begin
               xneg_in = x_raw[WIDTH-1];
               yneg_in = y_raw[WIDTH-1];
               quo_in  = x_mag;
               rem_in  = '0;
               acck_in = '0;
               accl_in = '0;
               cnt_in  = '0;
               ku_in   = WIDTH'(1);
               lv_in   = '0;
               if (y_mag == '0) begin
                  // Zero divisor: report the sign of x and |x| as the gcd.
                  kc_in    = WIDTH'(1);
                  lc_in    = '0;
                  b_in     = x_mag;
                  zero_in  = 1'b1;
                  state_in = ebz_pkg::ST_FIN;
               end else begin
                  kc_in    = '0;
                  lc_in    = WIDTH'(1);
                  b_in     = y_mag;
                  zero_in  = 1'b0;
                  state_in = ebz_pkg::ST_DIV;
               end
            end
         end
         ebz_pkg::ST_DIV: begin
            rem_in = ge ? WIDTH'(shifted - {1'b0, b_ff}) : shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
            // Quotient times coefficient, built MSB first as the bits appear.
            acck_in = {acck_ff[WIDTH-2:0], 1'b0} + (ge ? kc_ff : '0);
            accl_in = {accl_ff[WIDTH-2:0], 1'b0} + (ge ? lc_ff : '0);
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               state_in = ebz_pkg::ST_UPD;
            end
         end
         ebz_pkg::ST_UPD: begin
            if (rem_ff == '0) begin
               state_in = ebz_pkg::ST_FIN;
            end else begin
               kc_in    = ku_ff - acck_ff;
               ku_in    = kc_ff;
               lc_in    = lv_ff - accl_ff;
               lv_in    = lc_ff;
               quo_in   = b_ff;
               b_in     = rem_ff;
               rem_in   = '0;
               acck_in  = '0;
               accl_in  = '0;
               cnt_in   = '0;
               state_in = ebz_pkg::ST_DIV;
            end
         end
         ebz_pkg::ST_FIN: begin
            if (load_out) begin
               coef_x_in    = xneg_ff ? (~kc_ff + WIDTH'(1)) : kc_ff;
               coef_y_in    = yneg_ff ? (~lc_ff + WIDTH'(1)) : lc_ff;
               gcd_in       = b_ff[WIDTH-2:0];
               zflag_in     = zero_ff;
               rsp_valid_in = 1'b1;
               state_in     = ebz_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ebz_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ebz_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff      <= b_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      acck_ff   <= acck_in;
      accl_ff   <= accl_in;
      kc_ff     <= kc_in;
      ku_ff     <= ku_in;
      lc_ff     <= lc_in;
      lv_ff     <= lv_in;
      xneg_ff   <= xneg_in;
      yneg_ff   <= yneg_in;
      zero_ff   <= zero_in;
      coef_x_ff <= coef_x_in;
      coef_y_ff <= coef_y_in;
      gcd_ff    <= gcd_in;
      zflag_ff  <= zflag_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.coef_x       = coef_x_ff;
   assign rsp_chan.coef_y       = coef_y_ff;
   assign rsp_chan.divisor_out  = gcd_ff;
   assign rsp_chan.zero_divisor = zflag_ff;

   // The divisor never reaches zero inside a division, and the partial
   // remainder stays below it.
   `EBZ_ASSERT(a_div_nonzero, (state_ff != ebz_pkg::ST_DIV) || (b_ff != '0), "divisor is zero")
   `EBZ_ASSERT(a_rem_below, (state_ff != ebz_pkg::ST_DIV) || (rem_ff < b_ff), "remainder too big")
   // A new result appears only as the sequencer leaves its final state.
   `EBZ_ASSERT(a_rsp_from_fin, !$rose(rsp_valid_ff) || ($past(state_ff) == ebz_pkg::ST_FIN), "stray result")
   // An accepted operand pair always starts either a division or the zero rule.
   `EBZ_ASSERT_NEXT(a_start, req_fire, (state_ff == ebz_pkg::ST_DIV) || (state_ff == ebz_pkg::ST_FIN), "bad start")

endmodule

`default_nettype wire

// ===== sim/ebz_bezout_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the Bezout unit, computes the coefficients and gcd
// for every operand transfer and compares them with the result transfers in order.
module ebz_bezout_checker (
   input  wire logic clock,
   input  wire logic reset,
   ebz_req_if        req_mon,
   ebz_rsp_if        rsp_mon,
   output int        mismatch_count,
   output int        pending_results
);

   localparam int W = ebz_pkg::WIDTH_DEFAULT;
   localparam int REPORT_LIMIT = 10;
   localparam bit [63:0] OP_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - W);

   typedef struct packed {
      logic signed [W-1:0] coef_x;
      logic signed [W-1:0] coef_y;
      logic        [W-2:0] divisor;
      logic                zero_div;
   } bezout_type;

   typedef struct {
      logic [W-1:0] x;
      logic [W-1:0] y;
      bezout_type   result;
   } bezout_job_type;

   bezout_job_type bezout_q[$];
   int             fail_total = 0;

   // The most negative operand keeps its full magnitude of 2^(W-1).
   function automatic bit [63:0] magnitude(input logic [W-1:0] raw);
      bit [63:0] v;
      v = 64'(raw);
      if (raw[W-1]) return (~v + 64'd1) & OP_MASK;
      return v;
   endfunction

   function automatic bezout_type solve_bezout(input logic [W-1:0] x, input logic [W-1:0] y);
      bezout_type res;
      bit [63:0]  a, b, q, r, t;
      bit [63:0]  k_cur, l_cur, k_prev, l_prev;
      a = magnitude(x);
      b = magnitude(y);
      k_cur  = 64'd0;
      l_cur  = 64'd1;
      k_prev = 64'd1;
      l_prev = 64'd0;
      if (b == 64'd0) begin
         res.coef_x   = x[W-1] ? {W{1'b1}} : W'(1);
         res.coef_y   = '0;
         res.divisor  = a[W-2:0];
         res.zero_div = 1'b1;
         return res;
      end
      while (a % b != 64'd0) begin
         q = a / b;
         r = a - q * b;
         a = b;
         b = r;
         t = k_cur;
         k_cur = k_prev - q * k_cur;
         k_prev = t;
         t = l_cur;
         l_cur = l_prev - q * l_cur;
         l_prev = t;
      end
      if (x[W-1]) k_cur = 64'd0 - k_cur;
      if (y[W-1]) l_cur = 64'd0 - l_cur;
      res.coef_x   = k_cur[W-1:0];
      res.coef_y   = l_cur[W-1:0];
      res.divisor  = b[W-2:0];
      res.zero_div = 1'b0;
      return res;
   endfunction

   // Results are handled before operands so that a result arriving with nothing
   // outstanding is caught even when an operand transfer falls on the same edge.
   always @(posedge clock) begin
      bezout_job_type job;
      bezout_type     got;
      if (reset) begin
         bezout_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.coef_x   = rsp_mon.coef_x;
            got.coef_y   = rsp_mon.coef_y;
            got.divisor  = rsp_mon.divisor_out;
            got.zero_div = rsp_mon.zero_divisor;
            if (bezout_q.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT)
                  $display("%0t: unexpected result k=%0d l=%0d gcd=%0d zero=%0b", $realtime,
                           got.coef_x, got.coef_y, got.divisor, got.zero_div);
            end else begin
               job = bezout_q.pop_front();
               if (got.coef_x !== job.result.coef_x || got.coef_y !== job.result.coef_y ||
                   got.divisor !== job.result.divisor ||
                   got.zero_div !== job.result.zero_div) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT) begin
                     $display("%0t: mismatch for x=%0d y=%0d", $realtime,
                              $signed(job.x), $signed(job.y));
                     $display("   expected k=%0d l=%0d gcd=%0d zero=%0b",
                              job.result.coef_x, job.result.coef_y,
                              job.result.divisor, job.result.zero_div);
                     $display("   actual   k=%0d l=%0d gcd=%0d zero=%0b",
                              got.coef_x, got.coef_y, got.divisor, got.zero_div);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            job.x      = req_mon.x_value;
            job.y      = req_mon.y_value;
            job.result = solve_bezout(req_mon.x_value, req_mon.y_value);
            bezout_q.push_back(job);
         end
      end
      mismatch_count  <= fail_total;
      pending_results <= bezout_q.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int W = ebz_pkg::WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 370;
   localparam int HOLD_CYCLES = 4000;
   localparam int DRAIN_CYCLES = 1600;
   // Slowest run is roughly 400 worst-case items plus stalls; allow several times that.
   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   hold_rsp = 1'b0;
   bit   steady_flow = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count;
   int   pending_results;

   ebz_req_if #(.WIDTH(W)) req_bus ();
   ebz_rsp_if #(.WIDTH(W)) rsp_bus ();

   extended_euclid_bezout_unit #(.WIDTH(W)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   ebz_bezout_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("extended_euclid_bezout_unit regression: fail");
         $finish;
      end
   end

   function automatic int unsigned fib(input int n);
      int unsigned a, b, t;
      a = 0;
      b = 1;
      for (int i = 0; i < n; i++) begin
         t = a + b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic logic [W-1:0] random_sign(input logic [W-1:0] mag);
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic logic [W-1:0] random_extreme();
      case ($urandom_range(0, 6))
         0: return MOST_POS;
         1: return MOST_NEG;
         2: return MOST_NEG + 1'b1;
         3: return W'(1);
         4: return {W{1'b1}};
         5: return W'(0);
         default: return {2'b01, {(W-2){1'b0}}};
      endcase
   endfunction

   function automatic void pick_operands(output logic [W-1:0] x, output logic [W-1:0] y);
      logic [W-1:0] mask;
      int           idx;
      int unsigned  g;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            x = $urandom;
            y = $urandom;
         end
         4: begin
            mask = {W{1'b1}} >> (W - $urandom_range(1, W - 1));
            x = random_sign($urandom & mask);
            mask = {W{1'b1}} >> (W - $urandom_range(1, W - 1));
            y = random_sign($urandom & mask);
         end
         5: begin
            g = $urandom_range(1, 65535);
            x = random_sign(W'(g * $urandom_range(1, 32767)));
            y = random_sign(W'(g * $urandom_range(1, 32767)));
         end
         6: begin
            // Consecutive Fibonacci numbers need the most Euclid rounds.
            idx = $urandom_range(2, 46);
            x = random_sign(W'(fib(idx)));
            y = random_sign(W'(fib(idx - 1)));
            if ($urandom_range(0, 1)) begin
               mask = x;
               x = y;
               y = mask;
            end
         end
         7: begin
            case ($urandom_range(0, 2))
               0: begin x = $urandom; y = '0; end
               1: begin x = '0; y = $urandom; end
               default: begin x = random_extreme(); y = '0; end
            endcase
         end
         8: begin
            x = random_extreme();
            y = $urandom_range(0, 1) ? random_extreme() : W'($urandom);
         end
         default: begin
            x = random_sign(W'($urandom_range(0, 64)));
            y = random_sign(W'($urandom_range(0, 64)));
         end
      endcase
   endfunction

   // Returns at the edge where the operand transfer took place, with valid still high.
   task automatic send_operands(input logic [W-1:0] x, input logic [W-1:0] y);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.x_value <= x;
      req_bus.y_value <= y;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // The count from the checker is registered, so it is first read at the following edge.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   initial begin
      int idle;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         idle = steady_flow ? 0 : $urandom_range(0, 7);
         if (idle > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   initial begin
      logic [W-1:0] x, y;
      req_bus.valid   <= 1'b0;
      req_bus.x_value <= '0;
      req_bus.y_value <= '0;
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Zero operands, signs, extremes and the worst case for the round count.
      send_operands('0, '0);
      send_operands(W'(5), '0);
      send_operands(-W'(5), '0);
      send_operands(MOST_NEG, '0);
      send_operands('0, W'(7));
      send_operands('0, -W'(7));
      send_operands(MOST_POS, MOST_POS);
      send_operands(MOST_POS, -MOST_POS);
      send_operands(-MOST_POS, MOST_POS);
      send_operands(-MOST_POS, -MOST_POS);
      send_operands(MOST_POS, W'(1));
      send_operands(W'(1), MOST_POS);
      send_operands({W{1'b1}}, {W{1'b1}});
      send_operands(MOST_NEG, MOST_NEG);
      send_operands(MOST_NEG, W'(6));
      send_operands(W'(3), MOST_NEG);
      send_operands(W'(12), W'(18));
      send_operands(-W'(12), W'(18));
      send_operands(W'(12), -W'(18));
      send_operands(W'(fib(46)), W'(fib(45)));
      send_operands(-W'(fib(45)), W'(fib(46)));
      send_operands(MOST_POS, MOST_POS - 1'b1);
      send_operands(W'(17), W'(5));
      send_operands(W'(6), W'(6));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 60) hold_rsp = 1'b1;
         if (n == 150) steady_flow = 1'b1;
         if (n == 190) steady_flow = 1'b0;
         if (n == 250) wait_for_results();
         pick_operands(x, y);
         send_operands(x, y);
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("extended_euclid_bezout_unit regression: pass");
      end else begin
         $display("extended_euclid_bezout_unit regression: fail");
      end
      $finish;
   end

endmodule
